@@ design/first_fit_slot_allocator_unit_assert.svh @@
// Assertion macros for the first-fit slot allocator.
// Used by the top level only; expects a clock named clk and reset rst.
`ifndef FIRST_FIT_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
// same-cycle implication
`define FFSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffsa assertion failed");
// next-cycle implication
`define FFSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffsa assertion failed");
`endif

@@ design/ffsa_pkg.sv @@
// Package for the first-fit slot allocator: widths, state codes, command structs.
// No dependencies.
`default_nettype none
package ffsa_pkg;
  localparam int Slots     = 256;
  localparam int SlotBits  = 8;
  localparam int ValueBits = 32;
  localparam int CountBits = 9;
  localparam int MissBits  = 16;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_CMP, ST_HIT, ST_MISS, ST_CLR
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic start;
    logic step;
    logic hit_wr;
    logic miss_wr;
  } cmd_t;

  typedef struct packed {
    logic fit;
    logic last;
    logic empty;
    logic out_free;
    logic clr_done;
  } status_t;
endpackage
`default_nettype wire

@@ design/ffsa_in_if.sv @@
// Channel interfaces for items in and results out.
// Depends on ffsa_pkg.
`default_nettype none
interface ffsa_in_if;
  import ffsa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [SlotBits-1:0]  slot;
  logic [ValueBits-1:0] amount;
  modport source (output valid, mode, slot, amount, input ready);
  modport sink   (input valid, mode, slot, amount, output ready);
endinterface

interface ffsa_out_if;
  import ffsa_pkg::*;
  logic                valid;
  logic                ready;
  logic                placed;
  logic [SlotBits-1:0] chosen_slot;
  logic [MissBits-1:0] miss_count;
  modport source (output valid, placed, chosen_slot, miss_count, input ready);
  modport sink   (input valid, placed, chosen_slot, miss_count, output ready);
endinterface
`default_nettype wire

@@ design/ffsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffsa_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         q
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/ffsa_ctrl.sv @@
// Controller state machine: accepts items and sequences the slot scan.
// Depends on ffsa_pkg.
`default_nettype none
module ffsa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_mode,
  output logic                   in_ready,
  input  wire ffsa_pkg::status_t status,
  output ffsa_pkg::cmd_t         cmd
);
  import ffsa_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_mode) state_next = status.empty ? ST_MISS : ST_RD;
      end
      ST_RD:   state_next = ST_CMP;
      ST_CMP: begin
        if (status.fit)       state_next = ST_HIT;
        else if (status.last) state_next = ST_MISS;
        else                  state_next = ST_RD;
      end
      ST_HIT:  if (status.out_free) state_next = ST_IDLE;
      ST_MISS: if (status.out_free) state_next = ST_IDLE;
      ST_CLR:  if (status.clr_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd         = '0;
    cmd.clr     = (state == ST_CLR);
    cmd.load    = accept && !in_mode;
    cmd.start   = accept && in_mode;
    cmd.step    = (state == ST_CMP) && !status.fit && !status.last;
    cmd.hit_wr  = (state == ST_HIT) && status.out_free;
    cmd.miss_wr = (state == ST_MISS) && status.out_free;
  end
endmodule
`default_nettype wire

@@ design/ffsa_dp.sv @@
// Datapath: slot RAM (capacity and used flag), scan index, miss counter, result register.
// Depends on ffsa_pkg and ffsa_ram.
`default_nettype none
module ffsa_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ffsa_pkg::cmd_t                 cmd,
  output ffsa_pkg::status_t                   status,
  input  wire logic [ffsa_pkg::SlotBits-1:0]  in_slot,
  input  wire logic [ffsa_pkg::ValueBits-1:0] in_amount,
  input  wire logic [ffsa_pkg::CountBits-1:0] basket_count,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_placed,
  output logic [ffsa_pkg::SlotBits-1:0]       out_chosen_slot,
  output logic [ffsa_pkg::MissBits-1:0]       out_miss_count
);
  import ffsa_pkg::*;

  logic [SlotBits-1:0]  idx;
  logic [CountBits-1:0] limit;
  logic [ValueBits-1:0] amount;
  logic [ValueBits:0]   slot_q;
  logic [ValueBits-1:0] cap_q;
  logic                 used_q;
  logic                 wr_en;
  logic [SlotBits-1:0]  wr_addr;
  logic [ValueBits:0]   wr_data;
  logic [MissBits-1:0]  misses;
  logic [MissBits-1:0]  misses_next;

  // word layout: {used, capacity}
  ffsa_ram #(.Width(ValueBits + 1), .Depth(Slots)) u_slot (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx),
    .q     (slot_q)
  );

  assign cap_q  = slot_q[ValueBits-1:0];
  assign used_q = slot_q[ValueBits];
  assign wr_en  = cmd.clr || cmd.load || cmd.hit_wr;

  always_comb begin
    wr_addr = in_slot;
    wr_data = {1'b0, in_amount};
    if (cmd.clr) begin
      wr_addr = idx;
      wr_data = '0;
    end else if (cmd.hit_wr) begin
      wr_addr = idx;
      wr_data = {1'b1, cap_q};
    end
  end

  assign misses_next     = (misses == '1) ? misses : misses + 1'b1;
  assign status.fit      = !used_q && (cap_q >= amount);
  assign status.last     = ({1'b0, idx} + 1'b1) == limit;
  assign status.empty    = (basket_count == '0);
  assign status.out_free = !out_valid || out_ready;
  assign status.clr_done = (idx == SlotBits'(Slots - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clr) begin
      idx <= idx + 1'b1;
    end else if (cmd.start) begin
      amount <= in_amount;
      idx    <= '0;
      limit  <= (basket_count > CountBits'(Slots)) ? CountBits'(Slots) : basket_count;
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      misses <= '0;
    end else begin
      if (cmd.load) misses <= '0;
      if (cmd.miss_wr) misses <= misses_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.hit_wr || cmd.miss_wr) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_wr) begin
      out_placed      <= 1'b1;
      out_chosen_slot <= idx;
      out_miss_count  <= misses;
    end else if (cmd.miss_wr) begin
      out_placed      <= 1'b0;
      out_chosen_slot <= '0;
      out_miss_count  <= misses_next;
    end
  end
endmodule
`default_nettype wire

@@ design/first_fit_slot_allocator_unit.sv @@
// First-fit slot allocator: top level, APB register and channel wiring.
// Depends on ffsa_pkg, ffsa_in_if/ffsa_out_if, ffsa_ctrl, ffsa_dp, assert header.
//
// in_ch carries words {mode, slot, amount}. A load word (mode 0) writes the
// slot's capacity, frees the slot and clears the miss count; it gives no
// result. A place word (mode 1) scans slots from zero up to
// min(basket_count, 256) and returns one word {placed, chosen_slot,
// miss_count} on out_ch. Each slot examined takes a RAM read state, then
// a compare state, since the read of the slot RAM is registered. One word
// is in flight at a time.
// The result sits in an output register; in_ch stays ready while it waits,
// so loads go on, and a following place word holds at the end of its scan
// until out_ch takes the earlier result.
// Reset (rst, synchronous) clears the miss count and sets basket_count to
// 256; a clearing pass then zeroes every capacity and frees every slot,
// and in_ch is not ready until it ends. basket_count is register 0 at byte
// address 0; the user must write it only while idle, the block does not check.
`default_nettype none
`include "first_fit_slot_allocator_unit_assert.svh"
module first_fit_slot_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  ffsa_in_if.sink          in_ch,
  ffsa_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import ffsa_pkg::*;

  logic [CountBits-1:0] basket_count;
  cmd_t                 cmd;
  status_t              status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-CountBits){1'b0}}, basket_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      basket_count <= CountBits'(Slots);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      basket_count <= pwdata[CountBits-1:0];
    end
  end

  ffsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ffsa_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_slot         (in_ch.slot),
    .in_amount       (in_ch.amount),
    .basket_count    (basket_count),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_placed      (out_ch.placed),
    .out_chosen_slot (out_ch.chosen_slot),
    .out_miss_count  (out_ch.miss_count)
  );

  `FFSA_ASSERT_NOW(a_miss_slot_zero, out_ch.valid && !out_ch.placed, out_ch.chosen_slot == '0)
  `FFSA_ASSERT_NOW(a_miss_counted, out_ch.valid && !out_ch.placed, out_ch.miss_count != '0)
  `FFSA_ASSERT_NEXT(a_place_busy, in_ch.valid && in_ch.ready && in_ch.mode, !in_ch.ready)
endmodule
`default_nettype wire
